[hw/rtl/nearest_centroid_assign_unit_defines.svh]
// assertion macros shared by the nearest centroid assignment rtl
`ifndef NEAREST_CENTROID_ASSIGN_UNIT_DEFINES_SVH
`define NEAREST_CENTROID_ASSIGN_UNIT_DEFINES_SVH

// same-cycle implication, checked while out of reset
`define NCA_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked while out of reset
`define NCA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hw/rtl/ncau_pkg.sv]
// shared types and constants for the nearest centroid assignment unit
`timescale 1ns / 1ps

package ncau_pkg;

    localparam int LABEL_W   = 4;
    localparam int CLUSTER_W = 4;
    localparam int FEATURE_W = 4;
    localparam int ACTIVE_W  = 5;
    localparam int DIST_W    = 36;

    localparam logic [ACTIVE_W-1:0] ACTIVE_RESET = 5'd16;
    localparam logic [DIST_W-1:0]   DIST_MAX     = {DIST_W{1'b1}};

    // action codes
    localparam logic ACT_LOAD   = 1'b0;
    localparam logic ACT_SAMPLE = 1'b1;

    // control part of one beat as it moves down the chain
    typedef struct packed {
        logic                 valid;
        logic                 action;
        logic [CLUSTER_W-1:0] cluster;
        logic [FEATURE_W-1:0] feature;
        logic                 last;
        logic [ACTIVE_W-1:0]  active;
    } beat_ctl_t;

    // best candidate found so far by the cells upstream
    typedef struct packed {
        logic [LABEL_W-1:0] label;
        logic [DIST_W-1:0]  distance;
    } best_t;

    // saturating add of two distances
    function automatic logic [DIST_W-1:0] sat_add(input logic [DIST_W-1:0] a,
                                                  input logic [DIST_W-1:0] b);
        logic [DIST_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[DIST_W] ? DIST_MAX : s[DIST_W-1:0];
    endfunction

endpackage

[hw/rtl/nearest_centroid_assign_unit.sv]
// top level of the nearest centroid assignment unit: cell chain and result register
`timescale 1ns / 1ps
`include "nearest_centroid_assign_unit_defines.svh"

// Streams k-means items through a chain of MAX_CLUSTERS cells, one per cluster.
// A load beat (action 0) writes one centroid component into the cell whose index
// matches its cluster; a sample beat (action 1) makes every active cell add the
// saturated squared difference to its running distance, and the beat marked last
// carries a running best (label, distance) down the chain, lower index winning on
// ties, before every running distance is cleared. Each cell is three register
// stages deep (component read, square, accumulate), so the chain takes one item
// per cycle while not stalled, and the result of a sample is registered on
// m_valid after its last beat has passed every cell. The whole chain stalls only
// when a result reaches the end while the result register is held by m_ready low.
// active_clusters (cfg_wdata, reset 16) is captured with each beat; zero acts as
// one and values above MAX_CLUSTERS act as MAX_CLUSTERS. Components never loaded
// read as undefined.
module nearest_centroid_assign_unit #(
    parameter int MAX_CLUSTERS = 16,
    parameter int MAX_FEATURES = 16,
    parameter int VALUE_BITS   = 16
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    // configuration
    input  logic                                  cfg_we,
    input  logic [ncau_pkg::ACTIVE_W-1:0]         cfg_wdata,
    // input beats
    input  logic                                  s_valid,
    output logic                                  s_ready,
    input  logic                                  s_action,
    input  logic [ncau_pkg::CLUSTER_W-1:0]        s_cluster,
    input  logic [ncau_pkg::FEATURE_W-1:0]        s_feature,
    input  logic signed [VALUE_BITS-1:0]          s_value,
    input  logic                                  s_last,
    // result beats
    output logic                                  m_valid,
    input  logic                                  m_ready,
    output logic [ncau_pkg::LABEL_W-1:0]          m_label,
    output logic [ncau_pkg::DIST_W-1:0]           m_distance
);

    logic [ncau_pkg::ACTIVE_W-1:0] active_reg;

    ncau_pkg::beat_ctl_t          chain_ctl   [MAX_CLUSTERS+1];
    logic signed [VALUE_BITS-1:0] chain_value [MAX_CLUSTERS+1];
    ncau_pkg::best_t              chain_best  [MAX_CLUSTERS+1];

    logic                          adv;
    logic                          tail_res;
    logic                          out_valid_reg;
    logic [ncau_pkg::LABEL_W-1:0]  out_label_reg;
    logic [ncau_pkg::DIST_W-1:0]   out_dist_reg;

    // active cluster count register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_reg <= ncau_pkg::ACTIVE_RESET;
        end else if (cfg_we) begin
            active_reg <= cfg_wdata;
        end
    end

    // head of the chain
    always_comb begin
        chain_ctl[0].valid   = s_valid;
        chain_ctl[0].action  = s_action;
        chain_ctl[0].cluster = s_cluster;
        chain_ctl[0].feature = s_feature;
        chain_ctl[0].last    = s_last;
        chain_ctl[0].active  = active_reg;
        chain_best[0].label    = '0;
        chain_best[0].distance = ncau_pkg::DIST_MAX;
    end
    assign chain_value[0] = s_value;

    // one cell per cluster
    for (genvar k = 0; k < MAX_CLUSTERS; k++) begin : g_cell
        ncau_cell #(
            .VALUE_BITS   (VALUE_BITS),
            .MAX_FEATURES (MAX_FEATURES),
            .CELL_IDX     (k)
        ) u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .en        (adv),
            .in_ctl    (chain_ctl[k]),
            .in_value  (chain_value[k]),
            .in_best   (chain_best[k]),
            .out_ctl   (chain_ctl[k+1]),
            .out_value (chain_value[k+1]),
            .out_best  (chain_best[k+1])
        );
    end

    // chain advances unless a result is blocked at the tail
    assign tail_res = chain_ctl[MAX_CLUSTERS].valid && chain_ctl[MAX_CLUSTERS].last
                      && (chain_ctl[MAX_CLUSTERS].action == ncau_pkg::ACT_SAMPLE);
    assign adv      = !out_valid_reg || m_ready || !tail_res;
    assign s_ready  = adv;

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (tail_res && adv) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (tail_res && adv) begin
            out_label_reg <= chain_best[MAX_CLUSTERS].label;
            out_dist_reg  <= chain_best[MAX_CLUSTERS].distance;
        end
    end

    assign m_valid    = out_valid_reg;
    assign m_label    = out_label_reg;
    assign m_distance = out_dist_reg;

    // a blocked result keeps the tail in place
    `NCA_ASSERT_NEXT(a_tail_hold, aclk, aresetn, tail_res && out_valid_reg && !m_ready,
        tail_res, "result at chain tail lost while stalled")
    // a taken result with nothing behind it empties the result register
    `NCA_ASSERT_NEXT(a_out_drain, aclk, aresetn, out_valid_reg && m_ready && !tail_res,
        !out_valid_reg, "result repeated after beat was taken")
    // input is refused only while a result waits at both ends
    `NCA_ASSERT_NOW(a_stall_cause, aclk, aresetn, !s_ready,
        out_valid_reg && tail_res, "chain stalled without a blocked result")

endmodule

[hw/rtl/ncau_cell.sv]
// one cluster cell: centroid store, squared difference and running distance
`timescale 1ns / 1ps
`include "nearest_centroid_assign_unit_defines.svh"

module ncau_cell #(
    parameter int VALUE_BITS   = 16,
    parameter int MAX_FEATURES = 16,
    parameter int CELL_IDX     = 0
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         en,
    input  ncau_pkg::beat_ctl_t          in_ctl,
    input  logic signed [VALUE_BITS-1:0] in_value,
    input  ncau_pkg::best_t              in_best,
    output ncau_pkg::beat_ctl_t          out_ctl,
    output logic signed [VALUE_BITS-1:0] out_value,
    output ncau_pkg::best_t              out_best
);

    localparam int FA = (MAX_FEATURES > 1) ? $clog2(MAX_FEATURES) : 1;

    logic signed [VALUE_BITS-1:0] comp_mem [MAX_FEATURES];

    logic [7:0]    feat_ext;
    logic [FA-1:0] mem_addr;
    logic          feat_ok;
    logic          cell_active;
    logic          load_hit;

    ncau_pkg::beat_ctl_t          ctl1_reg, ctl2_reg, ctl3_reg;
    logic signed [VALUE_BITS-1:0] val1_reg, val2_reg, val3_reg;
    ncau_pkg::best_t              best1_reg, best2_reg, best3_reg, best3_next;
    logic signed [VALUE_BITS-1:0] rd1_reg;
    logic                         take1_reg, take2_reg;
    logic [ncau_pkg::DIST_W-1:0]  sq2_reg;
    logic [ncau_pkg::DIST_W-1:0]  acc_reg, acc_next;
    logic [ncau_pkg::DIST_W-1:0]  sum;

    logic signed [VALUE_BITS:0] diff;
    logic [VALUE_BITS:0]        mag;
    logic [33:0]                mag_ext;
    logic [17:0]                mag_lo;
    logic [35:0]                prod;
    logic [ncau_pkg::DIST_W-1:0] sq;

    function automatic logic cell_active_on_last(input ncau_pkg::beat_ctl_t c);
        return (CELL_IDX == 0) || ({4'd0, c.active} > 9'(CELL_IDX));
    endfunction

    // address decode and membership of this cell
    assign feat_ext    = 8'(in_ctl.feature);
    assign mem_addr    = feat_ext[FA-1:0];
    assign feat_ok     = 9'(in_ctl.feature) < 9'(MAX_FEATURES);
    assign cell_active = (CELL_IDX == 0) || ({4'd0, in_ctl.active} > 9'(CELL_IDX));
    assign load_hit    = in_ctl.valid && (in_ctl.action == ncau_pkg::ACT_LOAD)
                         && (9'(in_ctl.cluster) == 9'(CELL_IDX)) && feat_ok;

    // centroid store: write on a matching load, registered read
    always_ff @(posedge aclk) begin
        if (en) begin
            if (load_hit) begin
                comp_mem[mem_addr] <= in_value;
            end
            rd1_reg <= comp_mem[mem_addr];
        end
    end

    // stage 1: beat captured alongside the component read
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctl1_reg.valid <= 1'b0;
        end else if (en) begin
            ctl1_reg <= in_ctl;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            val1_reg  <= in_value;
            best1_reg <= in_best;
            take1_reg <= in_ctl.valid && (in_ctl.action == ncau_pkg::ACT_SAMPLE)
                         && feat_ok && cell_active;
        end
    end

    // squared difference, saturated to the distance range
    always_comb begin
        diff    = (VALUE_BITS+1)'(val1_reg) - (VALUE_BITS+1)'(rd1_reg);
        mag     = diff[VALUE_BITS] ? (VALUE_BITS+1)'(-diff) : (VALUE_BITS+1)'(diff);
        mag_ext = 34'(mag);
        mag_lo  = mag_ext[17:0];
        prod    = mag_lo * mag_lo;
        sq      = (mag_ext > 34'h3FFFF) ? ncau_pkg::DIST_MAX : prod;
    end

    // stage 2: square registered
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctl2_reg.valid <= 1'b0;
        end else if (en) begin
            ctl2_reg <= ctl1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            val2_reg  <= val1_reg;
            best2_reg <= best1_reg;
            take2_reg <= take1_reg;
            sq2_reg   <= take1_reg ? sq : '0;
        end
    end

    // accumulate, compare against upstream best, clear at end of sample
    always_comb begin
        sum        = ncau_pkg::sat_add(acc_reg, sq2_reg);
        acc_next   = acc_reg;
        best3_next = best2_reg;
        if (ctl2_reg.valid && (ctl2_reg.action == ncau_pkg::ACT_SAMPLE)) begin
            if (ctl2_reg.last) begin
                acc_next = '0;
                if (cell_active_on_last(ctl2_reg) && (sum < best2_reg.distance)) begin
                    best3_next.label    = ncau_pkg::LABEL_W'(CELL_IDX);
                    best3_next.distance = sum;
                end
            end else begin
                acc_next = sum;
            end
        end
    end

    // stage 3: running distance and hand-off to the next cell
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctl3_reg.valid <= 1'b0;
            acc_reg        <= '0;
        end else if (en) begin
            ctl3_reg <= ctl2_reg;
            acc_reg  <= acc_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            val3_reg  <= val2_reg;
            best3_reg <= best3_next;
        end
    end

    assign out_ctl   = ctl3_reg;
    assign out_value = val3_reg;
    assign out_best  = best3_reg;

    // a finished sample leaves the running distance cleared
    `NCA_ASSERT_NEXT(a_acc_clear, aclk, aresetn,
        en && ctl2_reg.valid && (ctl2_reg.action == ncau_pkg::ACT_SAMPLE) && ctl2_reg.last,
        acc_reg == '0, "running distance not cleared after last feature")
    // the best distance handed on never grows
    `NCA_ASSERT_NEXT(a_best_mono, aclk, aresetn, en && ctl2_reg.valid,
        best3_reg.distance <= $past(best2_reg.distance), "best distance increased in cell")
    // a square only enters for a sample beat this cell takes part in
    `NCA_ASSERT_NOW(a_sq_gate, aclk, aresetn, !take2_reg, sq2_reg == '0,
        "square present without contributing beat")

endmodule

[verif/nearest_centroid_assign_unit_tb.sv]
// self-checking testbench for the nearest centroid assignment unit
`timescale 1ns / 1ps

module nearest_centroid_assign_unit_tb;

    localparam int NUM_CLUSTERS = 16;
    localparam int NUM_FEATURES = 16;
    // chain depth from the top-level header plus some slack
    localparam int DRAIN_CYCLES = 3 * NUM_CLUSTERS + 1 + 16;
    localparam int STALL_LIMIT  = 3000;
    localparam int HOLD_CYCLES  = 600;
    localparam int NUM_PHASES   = 9;
    localparam int PHASE_BEATS  = 142;
    localparam int NUM_ROWS     = 20;
    localparam int HOLD_PHASE   = 2;

    typedef struct packed {
        logic                           action;
        logic [ncau_pkg::CLUSTER_W-1:0] cluster;
        logic [ncau_pkg::FEATURE_W-1:0] feature;
        logic signed [15:0]             value;
        logic                           last;
    } beat_t;

    typedef struct packed {
        logic [ncau_pkg::LABEL_W-1:0] label;
        logic [ncau_pkg::DIST_W-1:0]  distance;
    } nearest_t;

    typedef struct packed {
        beat_t    beat;
        logic     typed;
        nearest_t res;
    } dir_row_t;

    typedef enum int {RX_OPEN, RX_COIN, RX_PATTERN, RX_MOSTLY} rx_mode_t;

    logic                           aclk;
    logic                           aresetn;
    logic                           cfg_we;
    logic [ncau_pkg::ACTIVE_W-1:0]  cfg_wdata;
    logic                           s_valid;
    logic                           s_ready;
    logic                           s_action;
    logic [ncau_pkg::CLUSTER_W-1:0] s_cluster;
    logic [ncau_pkg::FEATURE_W-1:0] s_feature;
    logic signed [15:0]             s_value;
    logic                           s_last;
    logic                           m_valid;
    logic                           m_ready;
    logic [ncau_pkg::LABEL_W-1:0]   m_label;
    logic [ncau_pkg::DIST_W-1:0]    m_distance;

    // predictor state
    logic signed [15:0]            centroid_q [NUM_CLUSTERS][NUM_FEATURES];
    logic [ncau_pkg::DIST_W-1:0]   dist_acc [NUM_CLUSTERS];
    logic [ncau_pkg::ACTIVE_W-1:0] active_cfg;

    nearest_t    nearest_q [$];
    int unsigned mismatch_count = 0;
    int unsigned beats_sent = 0;
    int unsigned burst_left = 0;
    logic        hold_req = 1'b0;

    // directed rows over an all-zero centroid table
    dir_row_t directed_rows [NUM_ROWS] = '{
        '{'{ncau_pkg::ACT_SAMPLE, 4'd9,  4'd0,  16'sh0000, 1'b1}, 1'b1, '{4'd0,  36'd0}},
        '{'{ncau_pkg::ACT_LOAD,   4'd0,  4'd0,  16'sh8000, 1'b1}, 1'b0, '0},
        '{'{ncau_pkg::ACT_LOAD,   4'd15, 4'd0,  16'sh7FFF, 1'b0}, 1'b0, '0},
        '{'{ncau_pkg::ACT_SAMPLE, 4'd0,  4'd0,  16'sh7FFF, 1'b1}, 1'b1, '{4'd15, 36'd0}},
        '{'{ncau_pkg::ACT_SAMPLE, 4'd0,  4'd0,  16'sh8000, 1'b1}, 1'b1, '{4'd0,  36'd0}},
        '{'{ncau_pkg::ACT_SAMPLE, 4'd0,  4'd0,  16'sh0001, 1'b1}, 1'b1, '{4'd1,  36'd1}},
        '{'{ncau_pkg::ACT_LOAD,   4'd3,  4'd5,  16'sh0064, 1'b0}, 1'b0, '0},
        '{'{ncau_pkg::ACT_SAMPLE, 4'd0,  4'd5,  16'sh0064, 1'b0}, 1'b0, '0},
        '{'{ncau_pkg::ACT_SAMPLE, 4'd0,  4'd15, 16'sh0000, 1'b1}, 1'b1, '{4'd3,  36'd0}},
        '{'{ncau_pkg::ACT_LOAD,   4'd7,  4'd15, 16'shFFFF, 1'b0}, 1'b0, '0},
        '{'{ncau_pkg::ACT_SAMPLE, 4'd0,  4'd15, 16'shFFFF, 1'b0}, 1'b0, '0},
        '{'{ncau_pkg::ACT_SAMPLE, 4'd0,  4'd15, 16'shFFFF, 1'b0}, 1'b0, '0},
        '{'{ncau_pkg::ACT_SAMPLE, 4'd0,  4'd0,  16'sh0000, 1'b1}, 1'b1, '{4'd7,  36'd0}},
        '{'{ncau_pkg::ACT_SAMPLE, 4'd15, 4'd0,  16'sh7FFF, 1'b0}, 1'b0, '0},
        '{'{ncau_pkg::ACT_SAMPLE, 4'd0,  4'd0,  16'sh8000, 1'b1}, 1'b0, '0},
        '{'{ncau_pkg::ACT_LOAD,   4'd10, 4'd8,  16'sh7FFF, 1'b1}, 1'b0, '0},
        '{'{ncau_pkg::ACT_SAMPLE, 4'd0,  4'd8,  16'sh8000, 1'b1}, 1'b1,
          '{4'd0,  36'd1073741824}},
        '{'{ncau_pkg::ACT_SAMPLE, 4'd6,  4'd9,  16'sh5A5A, 1'b0}, 1'b0, '0},
        '{'{ncau_pkg::ACT_SAMPLE, 4'd6,  4'd6,  16'shA5A5, 1'b1}, 1'b0, '0},
        '{'{ncau_pkg::ACT_LOAD,   4'd5,  4'd10, 16'sh1234, 1'b0}, 1'b0, '0}
    };

    nearest_centroid_assign_unit dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_action  (s_action),
        .s_cluster (s_cluster),
        .s_feature (s_feature),
        .s_value   (s_value),
        .s_last    (s_last),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_label   (m_label),
        .m_distance(m_distance)
    );

    // clock
    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    // step the nearest-centroid predictor by one accepted beat
    task automatic predict_nearest(input beat_t b, output logic has_res, output nearest_t res);
        int                          n;
        logic signed [17:0]          diff;
        logic [17:0]                 mag;
        logic [ncau_pkg::DIST_W-1:0] sq;
        logic [ncau_pkg::DIST_W:0]   sum;
        has_res = 1'b0;
        res = '0;
        if (b.action == ncau_pkg::ACT_LOAD) begin
            centroid_q[b.cluster][b.feature] = b.value;
            return;
        end
        n = (active_cfg == 0) ? 1 :
            (active_cfg > NUM_CLUSTERS) ? NUM_CLUSTERS : int'(active_cfg);
        // every active cluster accumulates, saturating at the top of the range
        for (int k = 0; k < n; k++) begin
            diff = 18'(b.value) - 18'(centroid_q[k][b.feature]);
            mag = diff[17] ? -diff : diff;
            sq = ncau_pkg::DIST_W'(mag) * ncau_pkg::DIST_W'(mag);
            sum = {1'b0, dist_acc[k]} + {1'b0, sq};
            dist_acc[k] = sum[ncau_pkg::DIST_W] ? {ncau_pkg::DIST_W{1'b1}}
                                                : sum[ncau_pkg::DIST_W-1:0];
        end
        if (!b.last) begin
            return;
        end
        // search, lower index wins ties
        res.label = '0;
        res.distance = dist_acc[0];
        for (int k = 1; k < n; k++) begin
            if (dist_acc[k] < res.distance) begin
                res.distance = dist_acc[k];
                res.label = ncau_pkg::LABEL_W'(k);
            end
        end
        has_res = 1'b1;
        for (int k = 0; k < NUM_CLUSTERS; k++) begin
            dist_acc[k] = '0;
        end
    endtask

    // offer one beat, called at a falling edge, returns at a falling edge
    task automatic send_beat(input beat_t b, input logic typed, input nearest_t typed_res);
        logic     has_res;
        nearest_t res;
        s_valid   <= 1'b1;
        s_action  <= b.action;
        s_cluster <= b.cluster;
        s_feature <= b.feature;
        s_value   <= b.value;
        s_last    <= b.last;
        do begin
            @(posedge aclk);
        end while (!s_ready);
        predict_nearest(b, has_res, res);
        if (has_res) begin
            nearest_q.push_back(typed ? typed_res : res);
        end
        beats_sent++;
        @(negedge aclk);
        // bursts of random length with random gaps
        if (burst_left == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(negedge aclk);
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 200)
                                                      : $urandom_range(0, 30);
        end else begin
            burst_left--;
        end
    endtask

    // wait until every result is back and the chain has emptied
    task automatic drain_chain();
        s_valid <= 1'b0;
        while (nearest_q.size() != 0) begin
            @(negedge aclk);
        end
        repeat (DRAIN_CYCLES) @(negedge aclk);
    endtask

    task automatic write_active(input logic [ncau_pkg::ACTIVE_W-1:0] v);
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(negedge aclk);
        cfg_we <= 1'b0;
        active_cfg = v;
        @(negedge aclk);
    endtask

    // mix of wide, small, extreme and near-centroid values
    function automatic logic signed [15:0] pick_value(input logic [ncau_pkg::FEATURE_W-1:0] ft);
        int unsigned r;
        r = $urandom_range(0, 9);
        if (r < 3) begin
            return 16'($urandom);
        end else if (r < 5) begin
            return 16'(int'($urandom_range(0, 16)) - 8);
        end else if (r < 7) begin
            case ($urandom_range(0, 3))
                0: return 16'sh8000;
                1: return 16'sh7FFF;
                2: return 16'sh0000;
                default: return 16'shFFFF;
            endcase
        end
        return centroid_q[$urandom_range(0, NUM_CLUSTERS - 1)][ft] +
               16'(int'($urandom_range(0, 4)) - 2);
    endfunction

    // one random sequence: loads, a sample, a flood or noise
    task automatic run_sequence();
        int unsigned r;
        int unsigned len;
        int unsigned odd_pos;
        logic        broken;
        beat_t       b;
        r = $urandom_range(0, 99);
        if (r < 15) begin
            // a few centroid loads
            len = $urandom_range(1, 6);
            for (int i = 0; i < len; i++) begin
                b.action  = ncau_pkg::ACT_LOAD;
                b.cluster = ncau_pkg::CLUSTER_W'($urandom);
                b.feature = ncau_pkg::FEATURE_W'($urandom);
                b.value   = pick_value(b.feature);
                b.last    = 1'($urandom);
                send_beat(b, 1'b0, '0);
            end
        end else if (r < 18) begin
            // flood one feature far from cluster 0 until its sum saturates
            b = '{ncau_pkg::ACT_LOAD, 4'd0, 4'd0, 16'sh8000, 1'b0};
            send_beat(b, 1'b0, '0);
            for (int i = 0; i < 20; i++) begin
                b = '{ncau_pkg::ACT_SAMPLE, ncau_pkg::CLUSTER_W'($urandom), 4'd0,
                      16'sh7FFF, 1'(i == 19)};
                send_beat(b, 1'b0, '0);
            end
        end else if (r < 25) begin
            // noise: arbitrary features and last flags
            len = $urandom_range(1, 6);
            for (int i = 0; i < len; i++) begin
                b.action  = ncau_pkg::ACT_SAMPLE;
                b.cluster = ncau_pkg::CLUSTER_W'($urandom);
                b.feature = ncau_pkg::FEATURE_W'($urandom);
                b.value   = pick_value(b.feature);
                b.last    = 1'($urandom);
                send_beat(b, 1'b0, '0);
            end
        end else begin
            // well-formed sample, now and then with one feature out of order
            len = $urandom_range(1, NUM_FEATURES);
            broken = ($urandom_range(0, 9) == 0);
            odd_pos = $urandom_range(0, len - 1);
            for (int i = 0; i < len; i++) begin
                b.action  = ncau_pkg::ACT_SAMPLE;
                b.cluster = ncau_pkg::CLUSTER_W'($urandom);
                b.feature = (broken && i == odd_pos) ? ncau_pkg::FEATURE_W'($urandom)
                                                     : ncau_pkg::FEATURE_W'(i);
                b.value   = pick_value(b.feature);
                b.last    = 1'(i == len - 1);
                send_beat(b, 1'b0, '0);
            end
        end
    endtask

    // stimulus and configuration
    initial begin
        logic [ncau_pkg::ACTIVE_W-1:0] phase_active [NUM_PHASES];
        int unsigned                   phase_end;
        beat_t                         b;
        aresetn   = 1'b0;
        cfg_we    = 1'b0;
        cfg_wdata = ncau_pkg::ACTIVE_RESET;
        s_valid   = 1'b0;
        s_action  = ncau_pkg::ACT_LOAD;
        s_cluster = '0;
        s_feature = '0;
        s_value   = '0;
        s_last    = 1'b0;
        active_cfg = ncau_pkg::ACTIVE_RESET;
        for (int k = 0; k < NUM_CLUSTERS; k++) begin
            dist_acc[k] = '0;
            for (int f = 0; f < NUM_FEATURES; f++) begin
                centroid_q[k][f] = '0;
            end
        end
        phase_active = '{5'd1, 5'd0, 5'd31, 5'd17, 5'd16, 5'd2, 5'd15,
                         ncau_pkg::ACTIVE_W'($urandom_range(1, 16)),
                         ncau_pkg::ACTIVE_W'($urandom_range(0, 31))};
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // every component gets written before any sample reads it
        for (int k = 0; k < NUM_CLUSTERS; k++) begin
            for (int f = 0; f < NUM_FEATURES; f++) begin
                b = '{ncau_pkg::ACT_LOAD, ncau_pkg::CLUSTER_W'(k), ncau_pkg::FEATURE_W'(f),
                      16'sh0000, 1'b0};
                send_beat(b, 1'b0, '0);
            end
        end

        // directed rows at the reset cluster count
        for (int i = 0; i < NUM_ROWS; i++) begin
            send_beat(directed_rows[i].beat, directed_rows[i].typed, directed_rows[i].res);
        end
        drain_chain();

        // random phases over several cluster counts
        for (int p = 0; p < NUM_PHASES; p++) begin
            write_active(phase_active[p]);
            if (p == HOLD_PHASE) begin
                hold_req = 1'b1;
            end
            phase_end = beats_sent + PHASE_BEATS;
            while (beats_sent < phase_end) begin
                run_sequence();
            end
            // leave a sample open so the next count applies mid-sample
            if (p % 2 == 1) begin
                for (int i = 0; i < 2; i++) begin
                    b = '{ncau_pkg::ACT_SAMPLE, ncau_pkg::CLUSTER_W'($urandom),
                          ncau_pkg::FEATURE_W'(i), pick_value(4'(i)), 1'b0};
                    send_beat(b, 1'b0, '0);
                end
            end
            drain_chain();
        end

        if (mismatch_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

    // result side stalls on its own pattern, with one long hold-off
    initial begin
        rx_mode_t    mode;
        int unsigned span;
        logic [7:0]  pat;
        m_ready = 1'b0;
        @(posedge aresetn);
        forever begin
            if (hold_req) begin
                @(negedge aclk);
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge aclk);
                hold_req = 1'b0;
            end else begin
                mode = rx_mode_t'($urandom_range(0, 3));
                span = $urandom_range(8, 120);
                pat  = 8'($urandom);
                for (int k = 0; k < span && !hold_req; k++) begin
                    @(negedge aclk);
                    case (mode)
                        RX_OPEN:    m_ready <= 1'b1;
                        RX_COIN:    m_ready <= 1'($urandom);
                        RX_PATTERN: m_ready <= pat[k % 8];
                        default:    m_ready <= ($urandom_range(0, 7) != 0);
                    endcase
                end
            end
        end
    end

    // compare each result beat with the oldest expectation
    always @(posedge aclk) begin : result_check
        nearest_t want;
        if (aresetn && m_valid === 1'b1 && m_ready) begin
            if (nearest_q.size() == 0) begin
                $display("%0t: unexpected result label %0d distance %0d",
                         $time, m_label, m_distance);
                mismatch_count++;
            end else begin
                want = nearest_q.pop_front();
                if (m_label !== want.label) begin
                    $display("%0t: label expected %0d actual %0d", $time, want.label, m_label);
                    mismatch_count++;
                end
                if (m_distance !== want.distance) begin
                    $display("%0t: distance expected %0d actual %0d",
                             $time, want.distance, m_distance);
                    mismatch_count++;
                end
            end
        end
    end

    // watchdog on cycles without any beat
    initial begin
        int unsigned quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(posedge aclk);
            if ((s_valid && s_ready) || (m_valid && m_ready)) begin
                quiet = 0;
            end else begin
                quiet++;
            end
        end
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule
